// ===== design/hmhp_pkg.sv =====
//------------------------------------------------------------------------------
// hmhp_pkg
// Shared codes of the HTTP message head parser: phases, byte classes, events.
//------------------------------------------------------------------------------
`default_nettype none

package hmhp_pkg;

	localparam logic [4:0] PH_START      = 5'd0;
	localparam logic [4:0] PH_RQ_METHOD  = 5'd1;
	localparam logic [4:0] PH_RQ_SP1     = 5'd2;
	localparam logic [4:0] PH_RQ_URL     = 5'd3;
	localparam logic [4:0] PH_RQ_SP2     = 5'd4;
	localparam logic [4:0] PH_VER_PREFIX = 5'd5;
	localparam logic [4:0] PH_VER_MAJOR  = 5'd6;
	localparam logic [4:0] PH_VER_MINOR  = 5'd7;
	localparam logic [4:0] PH_RS_SP1     = 5'd8;
	localparam logic [4:0] PH_RS_CODE    = 5'd9;
	localparam logic [4:0] PH_RS_SP2     = 5'd10;
	localparam logic [4:0] PH_RS_REASON  = 5'd11;
	localparam logic [4:0] PH_LINE_LF    = 5'd12;
	localparam logic [4:0] PH_HDR_START  = 5'd13;
	localparam logic [4:0] PH_HDR_SKIP   = 5'd14;
	localparam logic [4:0] PH_HDR_KEY    = 5'd15;
	localparam logic [4:0] PH_HDR_VSKIP  = 5'd16;
	localparam logic [4:0] PH_HDR_VALUE  = 5'd17;
	localparam logic [4:0] PH_FIELD_LF   = 5'd18;
	localparam logic [4:0] PH_HEAD_LF    = 5'd19;
	localparam logic [4:0] PH_DONE       = 5'd20;

	localparam logic [3:0] CLS_SKIP    = 4'd0;
	localparam logic [3:0] CLS_METHOD  = 4'd1;
	localparam logic [3:0] CLS_URL     = 4'd2;
	localparam logic [3:0] CLS_VERSION = 4'd3;
	localparam logic [3:0] CLS_CODE    = 4'd4;
	localparam logic [3:0] CLS_REASON  = 4'd5;
	localparam logic [3:0] CLS_KEY     = 4'd6;
	localparam logic [3:0] CLS_VALUE   = 4'd7;
	localparam logic [3:0] CLS_LINEEND = 4'd8;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_REQ_DONE = 3'd1;
	localparam logic [2:0] EV_STA_DONE = 3'd2;
	localparam logic [2:0] EV_FIELD    = 3'd3;
	localparam logic [2:0] EV_HEAD     = 3'd4;
	localparam logic [2:0] EV_ERROR    = 3'd5;

	localparam logic CFG_MODE    = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_DOT   = 8'd46;

	function automatic logic [3:0] method_len(input logic [2:0] m);
		unique case (m)
			3'd0: method_len = 4'd7;
			3'd1: method_len = 4'd6;
			3'd2: method_len = 4'd3;
			3'd3: method_len = 4'd4;
			3'd4: method_len = 4'd4;
			3'd5: method_len = 4'd3;
			3'd6: method_len = 4'd7;
			default: method_len = 4'd5;
		endcase
	endfunction

	// Byte p of name m; zero beyond the name. The literals are right-justified,
	// so the first character sits in the highest used byte.
	function automatic logic [7:0] method_char(input logic [2:0] m, input logic [3:0] p);
		logic [63:0] s;
		logic [3:0]  n;
		logic [3:0]  idx;
		unique case (m)
			3'd0: s = "CONNECT";
			3'd1: s = "DELETE";
			3'd2: s = "GET";
			3'd3: s = "HEAD";
			3'd4: s = "POST";
			3'd5: s = "PUT";
			3'd6: s = "OPTIONS";
			default: s = "TRACE";
		endcase
		n = method_len(m);
		idx = n - 4'd1 - p;
		method_char = 8'd0;
		if (p < n) begin
			method_char = s[{idx[2:0], 3'b000} +: 8];
		end
	endfunction

	function automatic logic [7:0] prefix_char(input logic [3:0] p);
		unique case (p)
			4'd0: prefix_char = "H";
			4'd1: prefix_char = "T";
			4'd2: prefix_char = "T";
			4'd3: prefix_char = "P";
			4'd4: prefix_char = "/";
			default: prefix_char = 8'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== design/http_message_head_parser.sv =====
//------------------------------------------------------------------------------
// http_message_head_parser
// Byte-per-item parser of an HTTP request or status line and its header lines.
//------------------------------------------------------------------------------
// Channel   Direction  Handshake       Payload
// in        input      valid / stall   data_byte, message_start
// out       output     valid / stall   byte_class, event_res, method, version,
//                                      status_code, first_length, second_length
// cfg       input      valid / ready   cfg_index, cfg_data
//
// One byte is accepted per clock; its result appears in the output register on
// the next cycle. The parse state update is a single pass of per-phase logic.
// A byte is accepted while the output register is empty or being taken.
// Reset sets request mode and limit 4095, clears parse state and output valid.
//------------------------------------------------------------------------------
`default_nettype none

module http_message_head_parser
	import hmhp_pkg::*;
#(
	parameter int LENGTH_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        message_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       byte_class,
	output logic [2:0]       event_res,
	output logic [3:0]       method,
	output logic [1:0]       version,
	output logic [15:0]      status_code,
	output logic [11:0]      first_length,
	output logic [11:0]      second_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	logic                   mode_q;
	logic [11:0]            max_len_q;
	logic [4:0]             phase_q, phase_d;
	logic [3:0]             mpos_q, mpos_d;
	logic [7:0]             cand_q, cand_d;
	logic [7:0]             major_q, major_d, minor_q, minor_d;
	logic [15:0]            code_q, code_d;
	logic [LENGTH_BITS-1:0] tok_q, tok_d, tkey_q, tkey_d, saved_q, saved_d, line_q, line_d;
	logic                   err_q, err_d;

	logic [3:0]  cls;
	logic [2:0]  ev;
	logic [3:0]  mth;
	logic [1:0]  ver;
	logic [15:0] code_o;
	logic [LENGTH_BITS-1:0] len1, len2;
	logic        ok;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid && out_stall;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			max_len_q <= 12'd4095;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE:    mode_q    <= cfg_data[0];
				CFG_MAX_LEN: max_len_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		logic [4:0] ph;
		logic [3:0] mp;
		logic [7:0] cd;
		logic [7:0] mj, mn;
		logic [15:0] ca;
		logic [LENGTH_BITS-1:0] tk, tr, sv, ln;
		logic er;
		logic [LENGTH_BITS:0] nl;
		logic [19:0] cw;
		logic [7:0] keep;
		logic [7:0] b;
		logic crlf, dig;
		logic [3:0] dv;
		logic do_method, do_prefix, do_key;

		b = data_byte;
		if (message_start) begin
			ph = PH_START; mp = '0; cd = 8'hFF; mj = '0; mn = '0; ca = '0;
			tk = '0; tr = '0; sv = '0; ln = '0; er = 1'b0;
		end else begin
			ph = phase_q; mp = mpos_q; cd = cand_q; mj = major_q; mn = minor_q;
			ca = code_q; tk = tok_q; tr = tkey_q; sv = saved_q; ln = line_q; er = err_q;
		end
		cls = CLS_SKIP; ev = EV_NONE; mth = '0; ver = '0; code_o = '0;
		len1 = '0; len2 = '0; ok = 1'b1;
		crlf = (b == CH_CR) || (b == CH_LF);
		dig  = (b >= 8'd48) && (b <= 8'd57);
		dv   = b[3:0];
		do_method = 1'b0; do_prefix = 1'b0; do_key = 1'b0;
		nl = {1'b0, ln} + 1'b1;
		keep = '0;
		cw = '0;

		if (er) begin
			ev = EV_ERROR;
		end else if (ph != PH_DONE) begin
			if (!crlf) begin
				if (17'(nl) > 17'(max_len_q) || nl > {1'b0, LEN_MAX}) begin
					ok = 1'b0;
				end else begin
					ln = nl[LENGTH_BITS-1:0];
				end
			end
			if (ok) begin
				unique case (ph)
					PH_START: begin
						if (b != CH_SP) begin
							if (!mode_q) begin
								ph = PH_RQ_METHOD; cls = CLS_METHOD; do_method = 1'b1;
							end else begin
								mp = '0; cls = CLS_VERSION; do_prefix = 1'b1;
							end
						end
					end
					PH_RQ_METHOD: begin
						if (b == CH_SP) begin
							for (int i = 0; i < 8; i++) begin
								keep[i] = cd[i] && (method_len(3'(i)) == mp);
							end
							cd = keep; ok = (keep != 8'd0); ph = PH_RQ_SP1;
						end else begin
							cls = CLS_METHOD; do_method = 1'b1;
						end
					end
					PH_RQ_SP1: begin
						if (crlf) ok = 1'b0;
						else if (b != CH_SP) begin
							tk = LEN_ONE; ph = PH_RQ_URL; cls = CLS_URL;
						end
					end
					PH_RQ_URL: begin
						if (b == CH_SP) begin
							sv = tk; ph = PH_RQ_SP2;
						end else if (crlf) ok = 1'b0;
						else begin
							tk = tk + 1'b1; cls = CLS_URL;
						end
					end
					PH_RQ_SP2: begin
						if (b != CH_SP) begin
							mp = '0; cls = CLS_VERSION; do_prefix = 1'b1;
						end
					end
					PH_VER_PREFIX: begin
						cls = CLS_VERSION; do_prefix = 1'b1;
					end
					PH_VER_MAJOR: begin
						cls = CLS_VERSION;
						if (dig) mj = 8'({mj, 3'b0} + {mj, 1'b0} + {4'd0, dv});
						else if (b == CH_DOT) ph = PH_VER_MINOR;
						else ok = 1'b0;
					end
					PH_VER_MINOR: begin
						if (dig) begin
							mn = 8'({mn, 3'b0} + {mn, 1'b0} + {4'd0, dv}); cls = CLS_VERSION;
						end else if (!mode_q && b == CH_CR) begin
							ph = PH_LINE_LF; cls = CLS_LINEEND;
						end else if (mode_q && b == CH_SP) ph = PH_RS_SP1;
						else ok = 1'b0;
					end
					PH_RS_SP1: begin
						if (b != CH_SP) begin
							if (dig) begin
								ca = {12'd0, dv}; ph = PH_RS_CODE; cls = CLS_CODE;
							end else ok = 1'b0;
						end
					end
					PH_RS_CODE: begin
						if (dig) begin
							cw = {ca, 3'b0} + {ca, 1'b0} + {16'd0, dv};
							ca = (cw > 20'd65535) ? 16'hFFFF : cw[15:0];
							cls = CLS_CODE;
						end else if (b == CH_SP) begin
							tk = '0; ph = PH_RS_SP2;
						end else ok = 1'b0;
					end
					PH_RS_SP2: begin
						if (b == CH_CR) begin
							ph = PH_LINE_LF; cls = CLS_LINEEND;
						end else if (b == CH_LF) ok = 1'b0;
						else if (b != CH_SP) begin
							tk = LEN_ONE; ph = PH_RS_REASON; cls = CLS_REASON;
						end
					end
					PH_RS_REASON: begin
						if (b == CH_CR) begin
							ph = PH_LINE_LF; cls = CLS_LINEEND;
						end else if (b == CH_LF) ok = 1'b0;
						else begin
							tk = tk + 1'b1; cls = CLS_REASON;
						end
					end
					PH_LINE_LF: begin
						if (b != CH_LF) ok = 1'b0;
						else begin
							cls = CLS_LINEEND;
							if (mj == 8'd1 && mn == 8'd1) ver = 2'd3;
							else if (mj == 8'd1 && mn == 8'd0) ver = 2'd2;
							else if (mj == 8'd0 && mn == 8'd9) ver = 2'd1;
							if (!mode_q) begin
								ev = EV_REQ_DONE; len1 = sv;
								for (int i = 7; i >= 0; i--) begin
									if (cd[i]) mth = 4'(i + 1);
								end
							end else begin
								ev = EV_STA_DONE; code_o = ca; len1 = tk;
							end
							tk = '0; tr = '0; ln = '0; ph = PH_HDR_START;
						end
					end
					PH_HDR_START: begin
						if (b == CH_CR) begin
							ph = PH_HEAD_LF; cls = CLS_LINEEND;
						end else if (b == CH_SP) ph = PH_HDR_SKIP;
						else do_key = 1'b1;
					end
					PH_HDR_SKIP: begin
						if (b != CH_SP) do_key = 1'b1;
					end
					PH_HDR_KEY: do_key = 1'b1;
					PH_HDR_VSKIP: begin
						if (b == CH_CR) begin
							ph = PH_FIELD_LF; cls = CLS_LINEEND;
						end else if (b == CH_LF) ok = 1'b0;
						else if (b != CH_SP) begin
							tk = LEN_ONE; ph = PH_HDR_VALUE; cls = CLS_VALUE;
						end
					end
					PH_HDR_VALUE: begin
						if (b == CH_CR) begin
							ph = PH_FIELD_LF; cls = CLS_LINEEND;
						end else if (b == CH_LF) ok = 1'b0;
						else begin
							tk = tk + 1'b1; cls = CLS_VALUE;
						end
					end
					PH_FIELD_LF: begin
						if (b != CH_LF) ok = 1'b0;
						else begin
							cls = CLS_LINEEND; ev = EV_FIELD; len1 = tr; len2 = tk;
							tk = '0; tr = '0; ln = '0; ph = PH_HDR_START;
						end
					end
					PH_HEAD_LF: begin
						if (b != CH_LF) ok = 1'b0;
						else begin
							cls = CLS_LINEEND; ev = EV_HEAD; ln = '0; ph = PH_DONE;
						end
					end
					default: ok = 1'b0;
				endcase

				if (do_method) begin
					if (crlf) ok = 1'b0;
					else begin
						for (int i = 0; i < 8; i++) begin
							if (cd[i] && (mp >= method_len(3'(i))
									|| method_char(3'(i), mp) != b)) begin
								cd[i] = 1'b0;
							end
						end
						if (mp < 4'd15) mp = mp + 1'b1;
						ok = (cd != 8'd0);
					end
				end
				if (do_prefix) begin
					if (mp < 4'd5 && prefix_char(mp) == b) begin
						mp = mp + 1'b1;
						ph = (mp == 4'd5) ? PH_VER_MAJOR : PH_VER_PREFIX;
					end else ok = 1'b0;
				end
				if (do_key) begin
					if (crlf) ok = 1'b0;
					else if (b == CH_COLON) begin
						tk = '0; ph = PH_HDR_VSKIP; cls = CLS_SKIP;
					end else begin
						tk = tk + 1'b1;
						if (b != CH_SP) tr = tk;
						ph = PH_HDR_KEY; cls = CLS_KEY;
					end
				end
			end
			if (!ok) begin
				er = 1'b1; cls = CLS_SKIP; ev = EV_ERROR; mth = '0; ver = '0;
				code_o = '0; len1 = '0; len2 = '0;
			end
		end

		phase_d = ph; mpos_d = mp; cand_d = cd; major_d = mj; minor_d = mn; code_d = ca;
		tok_d = tk; tkey_d = tr; saved_d = sv; line_d = ln; err_d = er;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			mpos_q  <= '0;
			cand_q  <= 8'hFF;
			major_q <= '0;
			minor_q <= '0;
			code_q  <= '0;
			tok_q   <= '0;
			tkey_q  <= '0;
			saved_q <= '0;
			line_q  <= '0;
			err_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				mpos_q  <= mpos_d;
				cand_q  <= cand_d;
				major_q <= major_d;
				minor_q <= minor_d;
				code_q  <= code_d;
				tok_q   <= tok_d;
				tkey_q  <= tkey_d;
				saved_q <= saved_d;
				line_q  <= line_d;
				err_q   <= err_d;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_class    <= cls;
			event_res     <= ev;
			method        <= mth;
			version       <= ver;
			status_code   <= code_o;
			first_length  <= 12'(len1);
			second_length <= 12'(len2);
		end
	end

endmodule

`default_nettype wire

// ===== design/hmhp_checker.sv =====
//------------------------------------------------------------------------------
// hmhp_checker
// Port-level checks of the HTTP message head parser, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module hmhp_checker
	import hmhp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [3:0]  byte_class,
	input wire logic [2:0]  event_res,
	input wire logic [3:0]  method
);

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_class) && $stable(event_res))
		else $error("stalled result changed");

	// Input stalls only when a held result blocks the register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without back pressure");

	// An accepted byte always yields a result on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted byte gave no result");

	// An error result carries class zero and no method.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_ERROR |-> byte_class == CLS_SKIP && method == 4'd0)
		else $error("error result has payload");

endmodule

bind http_message_head_parser hmhp_checker u_hmhp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .byte_class(byte_class),
	.event_res(event_res), .method(method)
);

`default_nettype wire
